[rtl/ebw_pkg.sv]
`timescale 1ns / 1ps
package ebw_pkg;
   localparam int AngleBits    = 16;
   localparam int TrigFracBits = 16;
   localparam int CordicSteps  = 30;
   localparam int CordicFrac   = 30;
   localparam int CoordW       = 32;
   localparam int StageW       = 34;
   localparam int TrigW        = TrigFracBits + 2;
   localparam logic signed [34:0] CordicGain = 35'sd652032874;

   typedef logic signed [34:0] cw_type;

   typedef struct packed {
      cw_type      x;
      cw_type      y;
      logic signed [33:0] z;
   } rot_type;

   function automatic logic signed [33:0] atan_turn(input logic [4:0] i);
      logic signed [33:0] r;
      case (i)
         5'd0: r = 34'sh020000000;  5'd1: r = 34'sh012E4051E;
         5'd2: r = 34'sh009FB385B;  5'd3: r = 34'sh0051111D4;
         5'd4: r = 34'sh0028B0D43;  5'd5: r = 34'sh00145D7E1;
         5'd6: r = 34'sh000A2F61E;  5'd7: r = 34'sh000517C55;
         5'd8: r = 34'sh00028BE53;  5'd9: r = 34'sh000145F2F;
         5'd10: r = 34'sh0000A2F98; 5'd11: r = 34'sh0000517CC;
         5'd12: r = 34'sh000028BE6; 5'd13: r = 34'sh0000145F3;
         5'd14: r = 34'sh00000A2FA; 5'd15: r = 34'sh00000517D;
         5'd16: r = 34'sh0000028BE; 5'd17: r = 34'sh00000145F;
         5'd18: r = 34'sh000000A30; 5'd19: r = 34'sh000000518;
         5'd20: r = 34'sh00000028C; 5'd21: r = 34'sh000000146;
         5'd22: r = 34'sh0000000A3; 5'd23: r = 34'sh000000051;
         5'd24: r = 34'sh000000029; 5'd25: r = 34'sh000000014;
         5'd26: r = 34'sh00000000A; 5'd27: r = 34'sh000000005;
         5'd28: r = 34'sh000000003; 5'd29: r = 34'sh000000001;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic signed [TrigW-1:0] round_trig(input cw_type v);
      cw_type r;
      r = (v + (35'sd1 <<< (CordicFrac - TrigFracBits - 1)))
          >>> (CordicFrac - TrigFracBits);
      if (r > (35'sd1 <<< TrigFracBits)) r = 35'sd1 <<< TrigFracBits;
      if (r < -(35'sd1 <<< TrigFracBits)) r = -(35'sd1 <<< TrigFracBits);
      return r[TrigW-1:0];
   endfunction

   function automatic logic signed [StageW-1:0] mac2(
      input logic signed [StageW-1:0] a, input logic signed [TrigW-1:0] ca,
      input logic signed [StageW-1:0] b, input logic signed [TrigW-1:0] cb);
      logic signed [StageW+TrigW-1:0] pa, pb;
      logic signed [StageW+TrigW:0]   acc;
      pa = a * ca;
      pb = b * cb;
      acc = (StageW+TrigW+1)'(pa) + (StageW+TrigW+1)'(pb)
            + ((StageW+TrigW+1)'(1) <<< (TrigFracBits - 1));
      acc = acc >>> TrigFracBits;
      return acc[StageW-1:0];
   endfunction
endpackage

[rtl/euler_body_to_world_transform.sv]
`timescale 1ns / 1ps
// pipeline from request accept to result valid: 30 cordic cells,
// three rotation stages, one saturation stage
// throughput: one request per cycle when the output is not stalled
// each cell does one micro-rotation; the whole pipe advances when not stalled
// reset clears only the valid bits; payload registers are not reset
module euler_body_to_world_transform (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_body_x,
   input  logic signed [31:0] req_body_y,
   input  logic signed [31:0] req_body_z,
   input  logic [15:0]        req_roll_angle,
   input  logic [15:0]        req_heading_angle,
   input  logic [15:0]        req_pitch_angle,
   input  logic signed [31:0] req_origin_x,
   input  logic signed [31:0] req_origin_y,
   input  logic signed [31:0] req_origin_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_world_x,
   output logic signed [31:0] rsp_world_y,
   output logic signed [31:0] rsp_world_z,
   output logic               rsp_saturated
);
   import ebw_pkg::*;
   localparam int Lat = CordicSteps;
   localparam int Depth = Lat + 4;

   // whole pipe moves together; stall only when the output holds a result that is stalled
   logic adv;
   logic [Depth-1:0] vld_ff;
   assign adv = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[Depth-1];

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[Depth-2:0], req_valid};
   end

   // trig for three angles
   logic signed [TrigW-1:0] cr, sr, ch, sh, cp, sp;
   ebw_sincos u_roll  (.clock(clock), .enable(adv), .angle(req_roll_angle),
                       .cos_o(cr), .sin_o(sr));
   ebw_sincos u_head  (.clock(clock), .enable(adv), .angle(req_heading_angle),
                       .cos_o(ch), .sin_o(sh));
   ebw_sincos u_pitch (.clock(clock), .enable(adv), .angle(req_pitch_angle),
                       .cos_o(cp), .sin_o(sp));

   // coordinate delay line alongside the cordic chain
   logic signed [31:0] bx_ff [Lat], by_ff [Lat], bz_ff [Lat];
   logic signed [31:0] ox_ff [Lat+2], oy_ff [Lat+2], oz_ff [Lat+2];
   always_ff @(posedge clock) begin
      if (adv) begin
         bx_ff[0] <= req_body_x; by_ff[0] <= req_body_y; bz_ff[0] <= req_body_z;
         ox_ff[0] <= req_origin_x; oy_ff[0] <= req_origin_y;
         oz_ff[0] <= req_origin_z;
         for (int i = 1; i < Lat; i++) begin
            bx_ff[i] <= bx_ff[i-1]; by_ff[i] <= by_ff[i-1]; bz_ff[i] <= bz_ff[i-1];
         end
         for (int i = 1; i < Lat + 2; i++) begin
            ox_ff[i] <= ox_ff[i-1]; oy_ff[i] <= oy_ff[i-1]; oz_ff[i] <= oz_ff[i-1];
         end
      end
   end

   // stage 1: roll on x/y
   logic signed [StageW-1:0] x1_ff, y1_ff, z1_ff;
   logic signed [TrigW-1:0]  cp1_ff, sp1_ff, ch1_ff, sh1_ff, ch2_ff, sh2_ff;
   logic signed [StageW-1:0] x2_ff, y2_ff, z2_ff;
   logic signed [StageW:0]   wx_ff, wy_ff, wz_ff;
   logic signed [31:0]       wxo_ff, wyo_ff, wzo_ff;
   logic                     sat_ff;
   logic signed [StageW-1:0] bxe, bye;
   assign bxe = StageW'(bx_ff[Lat-1]);
   assign bye = StageW'(by_ff[Lat-1]);

   function automatic logic signed [31:0] sat(input logic signed [StageW:0] v);
      if (v > 35'sh07FFFFFFF) return 32'sh7FFFFFFF;
      if (v < -35'sh080000000) return 32'sh80000000;
      return v[31:0];
   endfunction
   function automatic logic ovf(input logic signed [StageW:0] v);
      return (v > 35'sh07FFFFFFF) || (v < -35'sh080000000);
   endfunction

   always_ff @(posedge clock) begin
      if (adv) begin
         x1_ff <= mac2(bxe, cr, bye, sr);
         y1_ff <= mac2(bye, cr, bxe, -sr);
         z1_ff <= StageW'(bz_ff[Lat-1]);
         cp1_ff <= cp; sp1_ff <= sp; ch1_ff <= ch; sh1_ff <= sh;
         // stage 2: pitch on y/z
         x2_ff <= x1_ff;
         y2_ff <= mac2(y1_ff, cp1_ff, z1_ff, -sp1_ff);
         z2_ff <= mac2(z1_ff, cp1_ff, y1_ff, sp1_ff);
         ch2_ff <= ch1_ff; sh2_ff <= sh1_ff;
         // stage 3: heading on z/x plus origin
         wx_ff <= (StageW+1)'(mac2(x2_ff, ch2_ff, z2_ff, -sh2_ff))
                  + (StageW+1)'(ox_ff[Lat+1]);
         wy_ff <= (StageW+1)'(y2_ff) + (StageW+1)'(oy_ff[Lat+1]);
         wz_ff <= (StageW+1)'(mac2(z2_ff, ch2_ff, x2_ff, sh2_ff))
                  + (StageW+1)'(oz_ff[Lat+1]);
         // stage 4: saturate
         wxo_ff <= sat(wx_ff); wyo_ff <= sat(wy_ff); wzo_ff <= sat(wz_ff);
         sat_ff <= ovf(wx_ff) | ovf(wy_ff) | ovf(wz_ff);
      end
   end

   assign rsp_world_x = wxo_ff;
   assign rsp_world_y = wyo_ff;
   assign rsp_world_z = wzo_ff;
   assign rsp_saturated = sat_ff;
endmodule

[rtl/ebw_cordic_cell.sv]
`timescale 1ns / 1ps
module ebw_cordic_cell (
   input  logic                clock,
   input  logic                enable,
   input  logic [4:0]          step,
   input  ebw_pkg::rot_type    rot_i,
   output ebw_pkg::rot_type    rot_o
);
   import ebw_pkg::*;
   rot_type rot_in;
   rot_type rot_ff;
   always_comb begin
      rot_in = rot_i;
      if (!rot_i.z[33]) begin
         rot_in.x = rot_i.x - (rot_i.y >>> step);
         rot_in.y = rot_i.y + (rot_i.x >>> step);
         rot_in.z = rot_i.z - atan_turn(step);
      end else begin
         rot_in.x = rot_i.x + (rot_i.y >>> step);
         rot_in.y = rot_i.y - (rot_i.x >>> step);
         rot_in.z = rot_i.z + atan_turn(step);
      end
   end
   always_ff @(posedge clock) begin
      if (enable) rot_ff <= rot_in;
   end
   assign rot_o = rot_ff;
endmodule

[rtl/ebw_sincos.sv]
`timescale 1ns / 1ps
module ebw_sincos (
   input  logic                               clock,
   input  logic                               enable,
   input  logic [15:0]                        angle,
   output logic signed [ebw_pkg::TrigW-1:0]   cos_o,
   output logic signed [ebw_pkg::TrigW-1:0]   sin_o
);
   import ebw_pkg::*;
   logic [31:0] t;
   logic [1:0]  q;
   logic [31:0] resid;
   rot_type     chain [CordicSteps+1];
   logic [1:0]  q_ff [CordicSteps];
   logic signed [TrigW-1:0] c, s;

   assign t = {angle[AngleBits-1:0], {(32-AngleBits){1'b0}}};
   assign q = 2'((t + 32'h2000_0000) >> 30);
   assign resid = t - {q, 30'd0};
   assign chain[0].x = CordicGain;
   assign chain[0].y = '0;
   assign chain[0].z = {{2{resid[31]}}, resid};

   for (genvar i = 0; i < CordicSteps; i++) begin : g_cell
      ebw_cordic_cell u_cell (
         .clock (clock), .enable(enable), .step(5'(i)),
         .rot_i (chain[i]), .rot_o(chain[i+1]));
      always_ff @(posedge clock) begin
         if (enable) q_ff[i] <= (i == 0) ? q : q_ff[(i == 0) ? 0 : i-1];
      end
   end

   assign c = round_trig(chain[CordicSteps].x);
   assign s = round_trig(chain[CordicSteps].y);
   always_comb begin
      case (q_ff[CordicSteps-1])
         2'd0: begin cos_o = c;  sin_o = s;  end
         2'd1: begin cos_o = -s; sin_o = c;  end
         2'd2: begin cos_o = -c; sin_o = -s; end
         default: begin cos_o = s; sin_o = -c; end
      endcase
   end
endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
module testbench;
   import ebw_pkg::*;

   // one request as sent to the block
   typedef struct {
      logic signed [31:0] bx, by, bz;
      logic [15:0]        roll, heading, pitch;
      logic signed [31:0] ox, oy, oz;
   } point_req_type;

   // one world point as produced by the block
   typedef struct {
      logic signed [31:0] wx, wy, wz;
      logic               sat;
   } world_pt_type;

   // directed row: request plus optional hand-typed answer
   typedef struct {
      point_req_type req;
      logic          typed;
      world_pt_type  res;
   } dir_row_type;

   localparam int  NumRandom  = 900;
   localparam int  CycleLimit = 200000;
   localparam int  DrainWait  = 60;
   localparam logic signed [31:0] MaxC = 32'sh7FFFFFFF;
   localparam logic signed [31:0] MinC = 32'sh80000000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_body_x = '0, req_body_y = '0, req_body_z = '0;
   logic [15:0]        req_roll_angle = '0, req_heading_angle = '0, req_pitch_angle = '0;
   logic signed [31:0] req_origin_x = '0, req_origin_y = '0, req_origin_z = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_world_x, rsp_world_y, rsp_world_z;
   logic               rsp_saturated;

   world_pt_type expected_points[$];
   int        n_errors = 0;
   int        n_checked = 0;
   int        n_sat = 0;
   int        cycle_count = 0;
   bit        stim_done = 1'b0;

   euler_body_to_world_transform dut (
      .clock, .reset,
      .req_valid, .req_stall,
      .req_body_x, .req_body_y, .req_body_z,
      .req_roll_angle, .req_heading_angle, .req_pitch_angle,
      .req_origin_x, .req_origin_y, .req_origin_z,
      .rsp_valid, .rsp_stall,
      .rsp_world_x, .rsp_world_y, .rsp_world_z, .rsp_saturated
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------

   // arithmetic shift right on a 64-bit signed value
   function automatic longint shr_arith(input longint v, input int s);
      return v >>> s;
   endfunction

   // trig value at 30 fraction bits down to 16, rounded half up, clamped to +-1
   function automatic longint trig_round(input longint v);
      longint r;
      r = shr_arith(v + (64'sd1 <<< (CordicFrac - TrigFracBits - 1)),
                    CordicFrac - TrigFracBits);
      if (r > (64'sd1 <<< TrigFracBits)) r = 64'sd1 <<< TrigFracBits;
      if (r < -(64'sd1 <<< TrigFracBits)) r = -(64'sd1 <<< TrigFracBits);
      return r;
   endfunction

   // cosine and sine of a binary angle by 30-step cordic and quadrant fold
   function automatic void angle_cos_sin(input logic [15:0] ang, output longint c,
                                         output longint s);
      longint      turn_step[30];
      logic [31:0] t, resid;
      logic [1:0]  q;
      longint      x, y, z, dx, dy, cc, ss;
      turn_step = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
                    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
                    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
                    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
                    64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
                    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
                    64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005,
                    64'h00000003, 64'h00000001};
      t = {ang, 16'h0000};
      q = 2'((t + 32'h20000000) >> 30);
      resid = t - ({30'd0, q} << 30);
      z = longint'($signed(resid));
      x = 652032874;
      y = 0;
      for (int i = 0; i < 30; i++) begin
         dx = shr_arith(y, i);
         dy = shr_arith(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= turn_step[i];
         end else begin
            x += dx; y -= dy; z += turn_step[i];
         end
      end
      cc = trig_round(x);
      ss = trig_round(y);
      case (q)
         2'd0: begin c = cc;  s = ss;  end
         2'd1: begin c = -ss; s = cc;  end
         2'd2: begin c = -cc; s = -ss; end
         default: begin c = ss; s = -cc; end
      endcase
   endfunction

   // two-term product sum rounded half up back to the coordinate lsb
   function automatic longint rot_pair(input longint a, input longint ca,
                                       input longint b, input longint cb);
      return shr_arith(a * ca + b * cb + (64'sd1 <<< (TrigFracBits - 1)), TrigFracBits);
   endfunction

   function automatic logic signed [31:0] clip32(input longint v, inout logic flag);
      if (v > longint'(MaxC)) begin flag = 1'b1; return MaxC; end
      if (v < longint'(MinC)) begin flag = 1'b1; return MinC; end
      return 32'(v);
   endfunction

   // roll on x/y, pitch on y/z, heading on z/x, then add the origin
   function automatic world_pt_type transform_point(input point_req_type p);
      world_pt_type w;
      longint    cr, sr, ch, sh, cp, sp;
      longint    x1, y1, z1, y2, z2;
      logic      flag;
      angle_cos_sin(p.roll, cr, sr);
      angle_cos_sin(p.heading, ch, sh);
      angle_cos_sin(p.pitch, cp, sp);
      flag = 1'b0;
      x1 = rot_pair(p.bx, cr, p.by, sr);
      y1 = rot_pair(p.by, cr, p.bx, -sr);
      z1 = p.bz;
      y2 = rot_pair(y1, cp, z1, -sp);
      z2 = rot_pair(z1, cp, y1, sp);
      w.wx = clip32(rot_pair(x1, ch, z2, -sh) + p.ox, flag);
      w.wy = clip32(y2 + p.oy, flag);
      w.wz = clip32(rot_pair(z2, ch, x1, sh) + p.oz, flag);
      w.sat = flag;
      return w;
   endfunction

   // ---------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------

   // after a random gap with valid low, present one request and hold it until accepted
   task automatic send_request(input point_req_type p, input world_pt_type exp_pt);
      int gap;
      gap = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_body_x        <= p.bx;
      req_body_y        <= p.by;
      req_body_z        <= p.bz;
      req_roll_angle    <= p.roll;
      req_heading_angle <= p.heading;
      req_pitch_angle   <= p.pitch;
      req_origin_x      <= p.ox;
      req_origin_y      <= p.oy;
      req_origin_z      <= p.oz;
      // accepted at the edge where valid is high and stall is low
      do @(posedge clock); while (req_stall);
      expected_points.push_back(exp_pt);
   endtask

   function automatic logic [31:0] rand_coord(input int mode);
      case (mode)
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 20000)) - 10000);
         2: return $urandom() >>> $urandom_range(4, 24);
         default: return $urandom_range(0, 1) ? MaxC - $urandom_range(0, 255)
                                               : MinC + $urandom_range(0, 255);
      endcase
   endfunction

   function automatic logic [15:0] rand_angle();
      case ($urandom_range(0, 3))
         0: return 16'($urandom_range(0, 3) * 16384 + $urandom_range(0, 2) - 1);
         1: return 16'($urandom_range(0, 7) * 8192);
         default: return 16'($urandom());
      endcase
   endfunction

   initial begin
      dir_row_type   rows[$];
      dir_row_type   r;
      point_req_type p;
      world_pt_type  w;
      int            mode;
      logic [15:0]   angs[8];

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table; typed answers only where they are obvious
      // all zero: origin only
      r = '{req: '{0, 0, 0, 0, 0, 0, 32'sd100, -32'sd100, 32'sd7}, typed: 1,
            res: '{32'sd100, -32'sd100, 32'sd7, 1'b0}};
      rows.push_back(r);
      // zero angles leave the point alone
      r = '{req: '{32'sd256, -32'sd512, 32'sd1024, 0, 0, 0, 0, 0, 0}, typed: 1,
            res: '{32'sd256, -32'sd512, 32'sd1024, 1'b0}};
      rows.push_back(r);
      // positive clipping at max origin
      r = '{req: '{MaxC, MaxC, MaxC, 0, 0, 0, MaxC, MaxC, MaxC}, typed: 1,
            res: '{MaxC, MaxC, MaxC, 1'b1}};
      rows.push_back(r);
      // negative clipping at min origin
      r = '{req: '{MinC, MinC, MinC, 0, 0, 0, MinC, MinC, MinC}, typed: 1,
            res: '{MinC, MinC, MinC, 1'b1}};
      rows.push_back(r);
      // max body with min origin cancels
      r = '{req: '{MaxC, MaxC, MaxC, 0, 0, 0, MinC, MinC, MinC}, typed: 1,
            res: '{-32'sd1, -32'sd1, -32'sd1, 1'b0}};
      rows.push_back(r);
      // quadrant corners, angle extremes and half-way residuals
      angs = '{16'h4000, 16'h8000, 16'hC000, 16'hFFFF,
               16'h2000, 16'h1FFF, 16'hE000, 16'h0001};
      for (int k = 0; k < 8; k++) begin
         r.typed = 0;
         r.req = '{32'sd25600, -32'sd12800, 32'sd6400, angs[k], 0, 0, 0, 0, 0};
         rows.push_back(r);
         r.req = '{32'sd25600, -32'sd12800, 32'sd6400, 0, angs[k], 0, 0, 0, 0};
         rows.push_back(r);
      end
      r.typed = 0;
      r.req = '{MaxC, MinC, MaxC, 16'h2000, 16'h2000, 16'h2000, 0, 0, 0};
      rows.push_back(r);
      r.req = '{MinC, MinC, MinC, 16'hA000, 16'h6000, 16'hE000, MaxC, MinC, 0};
      rows.push_back(r);
      r.req = '{-32'sd1, 32'sd1, -32'sd1, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0};
      rows.push_back(r);

      foreach (rows[i]) begin
         w = transform_point(rows[i].req);
         if (rows[i].typed && (w.wx !== rows[i].res.wx || w.wy !== rows[i].res.wy ||
                               w.wz !== rows[i].res.wz || w.sat !== rows[i].res.sat))
            $display("%0t note: predictor disagrees with directed row %0d", $time, i);
         send_request(rows[i].req, rows[i].typed ? rows[i].res : w);
      end

      for (int n = 0; n < NumRandom; n++) begin
         mode = $urandom_range(0, 3);
         p.bx = rand_coord(mode);
         p.by = rand_coord(mode);
         p.bz = rand_coord(mode);
         p.roll = rand_angle();
         p.heading = rand_angle();
         p.pitch = rand_angle();
         mode = $urandom_range(0, 3);
         p.ox = rand_coord(mode);
         p.oy = rand_coord(mode);
         p.oz = rand_coord(mode);
         send_request(p, transform_point(p));
      end
      req_valid <= 1'b0;

      while (expected_points.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);
      stim_done = 1'b1;
   end

   // ---------------------------------------------------------------
   // result side: random stall, compare at each accept
   // ---------------------------------------------------------------
   int stall_left = 0;

   always @(posedge clock) begin
      world_pt_type exp_pt;
      int           wait_n;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               $display("%0t unexpected result: x=%0d y=%0d z=%0d sat=%0b", $time,
                        rsp_world_x, rsp_world_y, rsp_world_z, rsp_saturated);
               n_errors++;
            end else begin
               exp_pt = expected_points.pop_front();
               n_checked++;
               if (exp_pt.sat) n_sat++;
               if (rsp_world_x !== exp_pt.wx) begin
                  $display("%0t world_x mismatch: expected %0d actual %0d", $time,
                           exp_pt.wx, rsp_world_x);
                  n_errors++;
               end
               if (rsp_world_y !== exp_pt.wy) begin
                  $display("%0t world_y mismatch: expected %0d actual %0d", $time,
                           exp_pt.wy, rsp_world_y);
                  n_errors++;
               end
               if (rsp_world_z !== exp_pt.wz) begin
                  $display("%0t world_z mismatch: expected %0d actual %0d", $time,
                           exp_pt.wz, rsp_world_z);
                  n_errors++;
               end
               if (rsp_saturated !== exp_pt.sat) begin
                  $display("%0t saturated mismatch: expected %0b actual %0b", $time,
                           exp_pt.sat, rsp_saturated);
                  n_errors++;
               end
            end
         end
         // after each accepted result, draw a fresh random stall
         if (rsp_valid && !rsp_stall) begin
            wait_n = $urandom_range(0, 3);
            rsp_stall  <= (wait_n != 0);
            stall_left <= (wait_n > 0) ? wait_n - 1 : 0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall  <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // end of run and watchdog
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (stim_done) begin
         if (expected_points.size() != 0) n_errors++;
         $display("checked %0d world points, %0d of them clipped", n_checked, n_sat);
         if (n_errors == 0)
            $display("Simulation PASSED");
         else
            $display("Simulation FAILED");
         $finish;
      end else if (cycle_count > CycleLimit) begin
         $display("timeout with %0d results outstanding", expected_points.size());
         $display("Simulation FAILED");
         $finish;
      end
   end
endmodule

[files.f]
rtl/ebw_pkg.sv
rtl/ebw_cordic_cell.sv
rtl/ebw_sincos.sv
rtl/euler_body_to_world_transform.sv
sim/testbench.sv
